>>> hw/rtl/pd_pkg.sv
// ----------------------------------------------------------------------------
// Percent decoder package
// Shared character constants, the hex digit helper and the result bundle
// that travels from the decode stage to the output buffer.
// ----------------------------------------------------------------------------
package pd_pkg;

	// Characters with special meaning in an encoded string.
	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_F = 8'h46;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_F = 8'h66;

	// Escape progress codes.
	localparam logic [1:0] PEND_NONE    = 2'd0;
	localparam logic [1:0] PEND_PERCENT = 2'd1;
	localparam logic [1:0] PEND_DIGIT   = 2'd2;

	// Most results one input byte can cause.
	localparam int MaxResults = 3;

	// Results of one input byte, in emission order.
	typedef struct packed {
		logic [MaxResults-1:0][7:0] bytes;
		logic [1:0]                 count;
		logic                       last;
	} pd_res_t;

	// Hex digit value in bits 3:0; bit 4 is set when the byte is no hex digit.
	function automatic logic [4:0] hex_value(input logic [7:0] c);
		logic [4:0] v;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			v = {1'b0, 4'(c - CH_ZERO)};
		end else if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
			v = {1'b0, 4'(c - CH_UPPER_A + 8'd10)};
		end else if (c >= CH_LOWER_A && c <= CH_LOWER_F) begin
			v = {1'b0, 4'(c - CH_LOWER_A + 8'd10)};
		end else begin
			v = 5'h10;
		end
		return v;
	endfunction

endpackage

>>> hw/rtl/pd_decode.sv
// ----------------------------------------------------------------------------
// Percent decoder escape stage
// Holds the pending escape state and turns one registered input byte into
// its list of up to three decoded bytes.
// ----------------------------------------------------------------------------
module pd_decode (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [7:0]     byte_s1,
	input  logic           last_s1,
	input  logic           advance,
	output pd_pkg::pd_res_t res
);
	import pd_pkg::*;

	logic [1:0] pend_q;
	logic [7:0] held_q;
	logic [1:0] pend_d;
	logic [7:0] held_d;
	logic [4:0] hv;
	logic [4:0] held_hv;
	logic       is_hex;

	assign hv      = hex_value(byte_s1);
	assign held_hv = hex_value(held_q);
	assign is_hex  = ~hv[4];

	// Build the result list by appending bytes in order.
	always_comb begin
		logic [1:0] n;
		logic       fresh;
		n      = 2'd0;
		fresh  = 1'b0;
		pend_d = PEND_NONE;
		held_d = held_q;
		res.bytes = '0;
		res.last  = last_s1;
		case (pend_q)
			PEND_PERCENT: begin
				if (is_hex && !last_s1) begin
					pend_d = PEND_DIGIT;
					held_d = byte_s1;
				end else begin
					res.bytes[n] = CH_PERCENT;
					n = n + 2'd1;
					fresh = 1'b1;
				end
			end
			PEND_DIGIT: begin
				if (is_hex) begin
					res.bytes[n] = {held_hv[3:0], hv[3:0]};
					n = n + 2'd1;
				end else begin
					res.bytes[n] = CH_PERCENT;
					n = n + 2'd1;
					res.bytes[n] = held_q;
					n = n + 2'd1;
					fresh = 1'b1;
				end
			end
			default: begin
				fresh = 1'b1;
			end
		endcase
		// The byte as seen from idle.
		if (fresh) begin
			if (byte_s1 == CH_PERCENT && !last_s1) begin
				pend_d = PEND_PERCENT;
			end else if (byte_s1 == CH_PLUS) begin
				res.bytes[n] = CH_SPACE;
				n = n + 2'd1;
			end else begin
				res.bytes[n] = byte_s1;
				n = n + 2'd1;
			end
		end
		// The final byte of a string always leaves the state idle.
		if (last_s1) begin
			pend_d = PEND_NONE;
			held_d = '0;
		end
		res.count = n;
	end

	// Escape state advances when the byte moves on to the output buffer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= PEND_NONE;
			held_q <= '0;
		end else if (advance) begin
			pend_q <= pend_d;
			held_q <= held_d;
		end
	end

endmodule

>>> hw/rtl/pd_out_buf.sv
// ----------------------------------------------------------------------------
// Percent decoder output buffer
// Stores the results of one input byte and hands them out one transaction
// per cycle while out_stall is low, flagging the last one of the run and of the string.
// ----------------------------------------------------------------------------
module pd_out_buf (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load,
	input  pd_pkg::pd_res_t res,
	output logic            free,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [7:0]      out_byte,
	output logic            run_end,
	output logic            string_end
);
	import pd_pkg::*;

	logic [MaxResults-1:0][7:0] ent_q;
	logic [1:0]                 cnt_q;
	logic [1:0]                 ptr_q;
	logic                       last_q;
	logic                       take;

	assign out_valid  = (cnt_q != 2'd0);
	assign out_byte   = ent_q[ptr_q];
	assign run_end    = (ptr_q == 2'(cnt_q - 2'd1));
	assign string_end = run_end & last_q;
	assign take       = out_valid & ~out_stall;

	// The buffer can take new results once the current run is fully delivered.
	assign free = ~out_valid | (take & run_end);

	// Control: count of stored results and the read pointer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			ptr_q <= 2'd0;
		end else if (load) begin
			cnt_q <= res.count;
			ptr_q <= 2'd0;
		end else if (take) begin
			if (run_end) begin
				cnt_q <= 2'd0;
				ptr_q <= 2'd0;
			end else begin
				ptr_q <= ptr_q + 2'd1;
			end
		end
	end

	// Payload of the stored run.
	always_ff @(posedge clk) begin
		if (load) begin
			ent_q  <= res.bytes;
			last_q <= res.last;
		end
	end

endmodule

>>> hw/rtl/percent_decoder.sv
// A byte is registered on acceptance and decoded combinationally; its results are
// offered once loaded into the free output buffer; an escape-only byte yields none.
// Throughput: one input byte per cycle while each byte yields at most one result
// and out_stall is low; a byte with more results holds the buffer till all are out.
// Reset: arst_n clears the input stage, the escape state and the output buffer.
// ----------------------------------------------------------------------------
// Percent decoder top level
// Streaming URI percent decoder with plus-as-space, built as an input
// register, an escape decode stage and a result buffer.
// ----------------------------------------------------------------------------
module percent_decoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       is_last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       run_end,
	output logic       string_end
);
	import pd_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       free;
	logic       advance;
	logic       accept;
	pd_res_t    res;

	assign advance  = valid_s1 & free;
	assign in_stall = valid_s1 & ~free;
	assign accept   = in_valid & ~in_stall;

	// Input stage valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Input stage payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= in_byte;
			last_s1 <= is_last;
		end
	end

	pd_decode u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_s1 (byte_s1),
		.last_s1 (last_s1),
		.advance (advance),
		.res     (res)
	);

	pd_out_buf u_out_buf (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (advance),
		.res        (res),
		.free       (free),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.run_end    (run_end),
		.string_end (string_end)
	);

endmodule

>>> tb/percent_decoder_test.sv
// ----------------------------------------------------------------------------
// Percent decoder testbench
// Feeds encoded strings byte by byte through the valid/stall handshake and
// checks every decoded byte and its end flags against an in-bench decoder.
// Strings start with hand-picked escape and flush cases and continue with
// random mixes of escapes, plus signs, broken escapes and arbitrary bytes.
// Both sides insert random gaps and stalls.
// ----------------------------------------------------------------------------
module percent_decoder_test;
	import pd_pkg::*;

	// One decoded byte as it should leave the block.
	typedef struct packed {
		logic [7:0] value;
		logic       run_end;
		logic       string_end;
	} decoded_t;

	// Tracks the escape state of the stream and the decoded bytes still owed.
	class decode_board;
		logic [1:0] esc_state;
		logic [7:0] esc_digit;
		decoded_t   expected_q[$];
		int         errors;
		int         bytes_in;
		int         bytes_out;
		int         strings_in;

		function new();
			esc_state = PEND_NONE;
			esc_digit = 8'h00;
			errors = 0;
			bytes_in = 0;
			bytes_out = 0;
			strings_in = 0;
		endfunction

		// Digit value in bits 3:0, bit 4 set for anything that is no hex digit.
		static function logic [4:0] nibble_of(logic [7:0] c);
			logic [4:0] v;
			v = 5'h10;
			if (c >= CH_ZERO && c <= CH_NINE) begin
				v = {1'b0, c[3:0]};
			end else if ((c >= CH_UPPER_A && c <= CH_UPPER_F) ||
				(c >= CH_LOWER_A && c <= CH_LOWER_F)) begin
				v = {1'b0, c[3:0] + 4'd9};
			end
			return v;
		endfunction

		function int waiting();
			return expected_q.size();
		endfunction

		function void push_byte(logic [7:0] b);
			decoded_t d;
			d.value = b;
			d.run_end = 1'b0;
			d.string_end = 1'b0;
			expected_q.insert(expected_q.size(), d);
		endfunction

		// A byte seen with nothing pending.
		function void plain_byte(logic [7:0] b, logic last);
			if (b == CH_PERCENT && !last) begin
				esc_state = PEND_PERCENT;
			end else if (b == CH_PLUS) begin
				push_byte(CH_SPACE);
			end else begin
				push_byte(b);
			end
		endfunction

		// Works out the decoded bytes owed for one accepted input transaction.
		function void note_byte(logic [7:0] b, logic last);
			logic [4:0] nib;
			logic [4:0] high_nib;
			logic [1:0] prev;
			int         first_new;
			decoded_t   d;
			nib = nibble_of(b);
			high_nib = nibble_of(esc_digit);
			prev = esc_state;
			first_new = expected_q.size();
			esc_state = PEND_NONE;
			bytes_in++;
			case (prev)
				PEND_PERCENT: begin
					if (!nib[4] && !last) begin
						esc_state = PEND_DIGIT;
						esc_digit = b;
					end else begin
						push_byte(CH_PERCENT);
						plain_byte(b, last);
					end
				end
				PEND_DIGIT: begin
					if (!nib[4]) begin
						push_byte({high_nib[3:0], nib[3:0]});
					end else begin
						push_byte(CH_PERCENT);
						push_byte(esc_digit);
						plain_byte(b, last);
					end
				end
				default: begin
					plain_byte(b, last);
				end
			endcase
			if (last) begin
				esc_digit = 8'h00;
				strings_in++;
			end
			// The final byte of this transaction carries the end flags.
			if (expected_q.size() > first_new) begin
				d = expected_q[expected_q.size() - 1];
				d.run_end = 1'b1;
				d.string_end = last;
				expected_q[expected_q.size() - 1] = d;
			end
		endfunction

		// Compares one accepted output transaction with the oldest owed byte.
		function void check_result(logic [7:0] b, logic re, logic se);
			decoded_t want;
			bytes_out++;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected output, out_byte %02h run_end %0b string_end %0b",
					$time, b, re, se);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			if (b !== want.value) begin
				$display("%0t: out_byte expected %02h actual %02h", $time, want.value, b);
				errors++;
			end
			if (re !== want.run_end) begin
				$display("%0t: run_end expected %0b actual %0b", $time, want.run_end, re);
				errors++;
			end
			if (se !== want.string_end) begin
				$display("%0t: string_end expected %0b actual %0b", $time,
					want.string_end, se);
				errors++;
			end
		endfunction

		function void flag_leftover();
			if (expected_q.size() != 0) begin
				$display("%0t: %0d decoded bytes never came out", $time, expected_q.size());
				errors += expected_q.size();
			end
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] in_byte = 8'h00;
	logic       is_last = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] out_byte;
	logic       run_end;
	logic       string_end;

	decode_board board;
	logic [7:0]  text_q[$];
	logic        calm = 1'b0;
	int          sent_items = 0;

	percent_decoder uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_byte   (in_byte),
		.is_last   (is_last),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.run_end   (run_end),
		.string_end(string_end)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watch both channels; every accepted transaction goes to the scoreboard.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				board.note_byte(in_byte, is_last);
			end
			if (out_valid && !out_stall) begin
				board.check_result(out_byte, run_end, string_end);
			end
		end
	end

	// Wait length before the next transaction; none during calm stretches.
	function automatic int pause_len();
		int n;
		n = calm ? 0 : $urandom_range(0, 14);
		return n;
	endfunction

	function automatic logic [7:0] hex_char(logic [3:0] v);
		logic [7:0] c;
		if (v < 4'd10) begin
			c = CH_ZERO + v;
		end else begin
			c = ($urandom_range(0, 1) ? CH_LOWER_A : CH_UPPER_A) + v - 8'd10;
		end
		return c;
	endfunction

	// Something that breaks an escape: another percent, a plus, or any other non-digit.
	function automatic logic [7:0] non_hex_char();
		logic [7:0] c;
		case ($urandom_range(0, 3))
			0: c = CH_PERCENT;
			1: c = CH_PLUS;
			default: begin
				c = 8'($urandom_range(0, 255));
				while (decode_board::nibble_of(c) < 5'd16) begin
					c = 8'($urandom_range(0, 255));
				end
			end
		endcase
		return c;
	endfunction

	task automatic load_text(string s);
		text_q.delete();
		for (int i = 0; i < s.len(); i++) begin
			text_q.insert(text_q.size(), s[i]);
		end
	endtask

	// Random tokens: well-formed escapes, plus signs, broken escapes, lone percents and bytes.
	task automatic fill_random_string();
		int tokens;
		int kind;
		text_q.delete();
		tokens = $urandom_range(1, 6);
		repeat (tokens) begin
			kind = $urandom_range(0, 19);
			if (kind < 8) begin
				text_q.insert(text_q.size(), CH_PERCENT);
				text_q.insert(text_q.size(), hex_char(4'($urandom_range(0, 15))));
				text_q.insert(text_q.size(), hex_char(4'($urandom_range(0, 15))));
			end else if (kind < 11) begin
				text_q.insert(text_q.size(), CH_PLUS);
			end else if (kind < 13) begin
				text_q.insert(text_q.size(), CH_PERCENT);
				text_q.insert(text_q.size(), hex_char(4'($urandom_range(0, 15))));
				text_q.insert(text_q.size(), non_hex_char());
			end else if (kind < 14) begin
				text_q.insert(text_q.size(), CH_PERCENT);
				text_q.insert(text_q.size(), non_hex_char());
			end else if (kind < 15) begin
				text_q.insert(text_q.size(), CH_PERCENT);
			end else begin
				text_q.insert(text_q.size(), 8'($urandom_range(0, 255)));
			end
		end
	endtask

	// Offer one input transaction after a random gap and hold it until taken.
	task automatic send_byte(logic [7:0] b, logic last);
		int gap;
		gap = pause_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= b;
		is_last <= last;
		do @(posedge clk); while (in_stall);
		sent_items++;
	endtask

	task automatic send_text();
		for (int i = 0; i < text_q.size(); i++) begin
			send_byte(text_q[i], i == text_q.size() - 1);
		end
	endtask

	// Hold off the sender until every owed byte has come out.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (board.waiting() != 0) @(posedge clk);
	endtask

	// Output side: random stall before each transaction.
	initial begin : result_sink
		int hold;
		@(posedge arst_n);
		forever begin
			hold = pause_len();
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin : stimulus
		int n_str;
		int w;
		board = new();
		n_str = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Upper and lower case digits, extreme and zero values, escape on the final byte.
		load_text("%41%6a%FF+%00");
		send_text();
		// Broken escapes: digit then non-digit, digit then a new percent, no digit.
		load_text("%4g%2%41%z");
		send_text();
		// Pending percent and digit flushed by a final plus.
		load_text("%4+");
		send_text();
		// A lone percent as the whole string.
		load_text("%");
		send_text();
		text_q = '{8'h00};
		send_text();
		text_q = '{8'hFF};
		send_text();
		settle();

		// Random strings, with calm stretches and periodic full drains.
		while (sent_items < 310) begin
			calm = ($urandom_range(0, 4) == 0);
			fill_random_string();
			send_text();
			n_str++;
			if (n_str % 12 == 0) begin
				settle();
			end
		end
		calm = 1'b0;
		in_valid <= 1'b0;

		// Drain, then keep watching for anything stray before the final check.
		for (w = 0; w < 2000 && board.waiting() != 0; w++) begin
			@(posedge clk);
		end
		repeat (10) @(posedge clk);
		board.flag_leftover();

		$display("Covered %0d strings, %0d random: %0d bytes in, %0d decoded bytes out.",
			board.strings_in, n_str, board.bytes_in, board.bytes_out);
		$display("Mismatches and missing or extra bytes: %0d.", board.errors);
		if (board.errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	// Guard against a hung handshake.
	initial begin : watchdog
		#2000000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
